### rtl/gimbal_search_scan_controller_macros.svh
// assertion macros shared by the gimbal search-scan checker
`ifndef GIMBAL_SEARCH_SCAN_CONTROLLER_MACROS_SVH
`define GIMBAL_SEARCH_SCAN_CONTROLLER_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define GSSC_ASSERT_SAME(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define GSSC_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/gssc_pkg.sv
// shared types and constants of the gimbal search-scan controller
`default_nettype none

package gssc_pkg;

    // lost-target timeout default, in ticks
    localparam int unsigned LOST_TIMEOUT_DEF = 800;
    localparam int unsigned LOST_W           = 10;

    // pitch saturation bound in micro-radians
    localparam logic signed [22:0] PITCH_LIMIT = 23'sd3141593;

    // remote switch positions
    localparam logic [1:0] SW_UP   = 2'd1;
    localparam logic [1:0] SW_DOWN = 2'd2;
    localparam logic [1:0] SW_MID  = 2'd3;

    // stick nudge: round(|s|*1000/660) = floor((100*|s| + 33) / 66),
    // done as a multiply by ceil(2^23/66) and a shift
    localparam logic [16:0] NUDGE_RECIP = 17'd127101;
    localparam int unsigned NUDGE_SHIFT = 23;

    // robot modes
    typedef enum logic [2:0] {
        MODE_OFF      = 3'd0,
        MODE_AUTO     = 3'd1,
        MODE_FOLLOW   = 3'd2,
        MODE_UNFOLLOW = 3'd3,
        MODE_SHOOT    = 3'd4,
        MODE_SPIN     = 3'd5,
        MODE_FIX      = 3'd6
    } mode_t;

    // configuration register indexes
    typedef enum logic [2:0] {
        REG_PITCH_STEP    = 3'd0,
        REG_YAW_STEP      = 3'd1,
        REG_PITCH_TOP     = 3'd2,
        REG_PITCH_BOTTOM  = 3'd3,
        REG_YAW_LOW_EDGE  = 3'd4,
        REG_YAW_LOW_TURN  = 3'd5,
        REG_YAW_HIGH_TURN = 3'd6,
        REG_YAW_HIGH_EDGE = 3'd7
    } cfg_idx_t;

    // configuration register set
    typedef struct packed {
        logic [16:0]        pitch_step;
        logic [9:0]         yaw_step;
        logic signed [22:0] pitch_top;
        logic signed [22:0] pitch_bottom;
        logic [12:0]        yaw_low_edge;
        logic [12:0]        yaw_low_turn;
        logic [12:0]        yaw_high_turn;
        logic [12:0]        yaw_high_edge;
    } cfg_t;

endpackage

`default_nettype wire

### rtl/gimbal_search_scan_controller.sv
// top level of the gimbal search-scan controller: stream ports and pipeline registers
`default_nettype none

// One control tick per clock cycle while results are not stalled. A tick is captured in an
// input register, stepped through the mode, nudge and scan logic once the output register
// is free or being drained, and its result lands in the output register.
// The rate is one tick per cycle, set by the registered state update of the scan
// accumulators; a stalled result holds the output register while one more tick waits
// in the input register. Configuration takes effect on the next stepped tick and
// should be written while no tick is in flight.

module gimbal_search_scan_controller #(
    parameter int unsigned LOST_TIMEOUT = gssc_pkg::LOST_TIMEOUT_DEF
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    // input ticks
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // [1:0] switch_left, [3:2] switch_right, [14:4] pitch_stick,
    // [15] target_found, [28:16] yaw_motor_angle, [31:29] zero
    input  wire logic [31:0]  s_tdata,
    // results
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // [22:0] pitch_cmd, [54:23] yaw_cmd, [57:55] drive_mode,
    // [58] vision_enabled, [59] scanning, [63:60] zero
    output logic [63:0]       m_tdata,
    // configuration writes
    input  wire logic         cfg_valid,
    output logic              cfg_ready,
    input  wire logic [2:0]   cfg_addr,
    input  wire logic [22:0]  cfg_wdata
);

    // pipeline registers
    logic        in_valid_reg, in_valid_next;
    logic [28:0] in_data_reg;
    logic        out_valid_reg, out_valid_next;
    logic [59:0] out_data_reg;
    logic        advance;

    // step results
    gssc_pkg::cfg_t     cfg;
    logic signed [22:0] res_pitch;
    logic signed [31:0] res_yaw;
    gssc_pkg::mode_t    res_mode;
    logic               res_vision;
    logic               res_scanning;

    assign cfg_ready = 1'b1;

    gssc_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr_en   (cfg_valid),
        .wr_addr (cfg_addr),
        .wr_data (cfg_wdata),
        .cfg     (cfg)
    );

    gssc_core #(
        .LOST_TIMEOUT (LOST_TIMEOUT)
    ) u_core (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .step_en         (advance),
        .cfg             (cfg),
        .switch_left     (in_data_reg[1:0]),
        .switch_right    (in_data_reg[3:2]),
        .pitch_stick     (in_data_reg[14:4]),
        .target_found    (in_data_reg[15]),
        .yaw_motor_angle (in_data_reg[28:16]),
        .pitch_cmd       (res_pitch),
        .yaw_cmd         (res_yaw),
        .drive_mode      (res_mode),
        .vision_enabled  (res_vision),
        .scanning        (res_scanning)
    );

    // a held tick steps when the output register is free or being drained
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_comb begin
        in_valid_next  = s_tready ? s_tvalid : in_valid_reg;
        out_valid_next = advance ? 1'b1 : (m_tready ? 1'b0 : out_valid_reg);
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload capture
    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_data_reg <= s_tdata[28:0];
        end
        if (advance) begin
            out_data_reg <= {res_scanning, res_vision, res_mode, res_yaw, res_pitch};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'd0, out_data_reg};

endmodule

`default_nettype wire

### rtl/gssc_cfg.sv
// configuration register file of the gimbal search-scan controller
`default_nettype none

module gssc_cfg (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                wr_en,
    input  wire logic [2:0]          wr_addr,
    input  wire logic [22:0]         wr_data,
    output gssc_pkg::cfg_t           cfg
);

    gssc_pkg::cfg_t cfg_reg;

    // register writes, reset to the default scan pattern
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.pitch_step    <= 17'd1000;
            cfg_reg.yaw_step      <= 10'd3;
            cfg_reg.pitch_top     <= 23'sd200000;
            cfg_reg.pitch_bottom  <= -23'sd200000;
            cfg_reg.yaw_low_edge  <= 13'd1950;
            cfg_reg.yaw_low_turn  <= 13'd2050;
            cfg_reg.yaw_high_turn <= 13'd6700;
            cfg_reg.yaw_high_edge <= 13'd6800;
        end else if (wr_en) begin
            case (gssc_pkg::cfg_idx_t'(wr_addr))
                gssc_pkg::REG_PITCH_STEP:    cfg_reg.pitch_step    <= wr_data[16:0];
                gssc_pkg::REG_YAW_STEP:      cfg_reg.yaw_step      <= wr_data[9:0];
                gssc_pkg::REG_PITCH_TOP:     cfg_reg.pitch_top     <= wr_data;
                gssc_pkg::REG_PITCH_BOTTOM:  cfg_reg.pitch_bottom  <= wr_data;
                gssc_pkg::REG_YAW_LOW_EDGE:  cfg_reg.yaw_low_edge  <= wr_data[12:0];
                gssc_pkg::REG_YAW_LOW_TURN:  cfg_reg.yaw_low_turn  <= wr_data[12:0];
                gssc_pkg::REG_YAW_HIGH_TURN: cfg_reg.yaw_high_turn <= wr_data[12:0];
                gssc_pkg::REG_YAW_HIGH_EDGE: cfg_reg.yaw_high_edge <= wr_data[12:0];
                default: ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

### rtl/gssc_core.sv
// per-tick step logic and scan state of the gimbal search-scan controller
`default_nettype none

module gssc_core #(
    parameter int unsigned LOST_TIMEOUT = gssc_pkg::LOST_TIMEOUT_DEF
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                step_en,
    input  wire gssc_pkg::cfg_t      cfg,
    input  wire logic [1:0]          switch_left,
    input  wire logic [1:0]          switch_right,
    input  wire logic signed [10:0]  pitch_stick,
    input  wire logic                target_found,
    input  wire logic [12:0]         yaw_motor_angle,
    output logic signed [22:0]       pitch_cmd,
    output logic signed [31:0]       yaw_cmd,
    output gssc_pkg::mode_t          drive_mode,
    output logic                     vision_enabled,
    output logic                     scanning
);

    // scan state
    logic signed [22:0]            pitch_accum_reg, pitch_accum_next;
    logic signed [31:0]            yaw_accum_reg, yaw_accum_next;
    logic                          pitch_down_reg, pitch_down_next;
    logic                          yaw_down_reg, yaw_down_next;
    logic [gssc_pkg::LOST_W-1:0]   lost_reg, lost_next;

    // mode decode
    gssc_pkg::mode_t mode;
    logic            manual;

    // nudge path
    logic [10:0]        stick_abs;
    logic [16:0]        nudge_num;
    logic [33:0]        nudge_prod;
    logic [10:0]        nudge_mag;
    logic signed [24:0] nudge_d;
    logic signed [24:0] manual_sum;

    // scan path
    logic signed [24:0] accum_ext;
    logic signed [24:0] pstep_ext;
    logic signed [24:0] pitch_move;
    logic signed [24:0] scan_pitch;
    logic               scan_pdown;
    logic               band_high, band_low;
    logic               scan_ydown;
    logic signed [32:0] yaw_move;
    logic signed [31:0] scan_yaw;

    // lost counter
    logic [gssc_pkg::LOST_W:0] lost_inc;
    logic                      lost_over;

    function automatic logic signed [22:0] clamp_pitch(input logic signed [24:0] v);
        logic signed [24:0] lim;
        lim = 25'(gssc_pkg::PITCH_LIMIT);
        if (v > lim) begin
            clamp_pitch = gssc_pkg::PITCH_LIMIT;
        end else if (v < -lim) begin
            clamp_pitch = -gssc_pkg::PITCH_LIMIT;
        end else begin
            clamp_pitch = v[22:0];
        end
    endfunction

    // switch pair to mode
    always_comb begin
        case ({switch_left, switch_right})
            {gssc_pkg::SW_UP,   gssc_pkg::SW_DOWN}: mode = gssc_pkg::MODE_AUTO;
            {gssc_pkg::SW_DOWN, gssc_pkg::SW_DOWN}: mode = gssc_pkg::MODE_FOLLOW;
            {gssc_pkg::SW_MID,  gssc_pkg::SW_MID}:  mode = gssc_pkg::MODE_UNFOLLOW;
            {gssc_pkg::SW_MID,  gssc_pkg::SW_UP}:   mode = gssc_pkg::MODE_SHOOT;
            {gssc_pkg::SW_MID,  gssc_pkg::SW_DOWN}: mode = gssc_pkg::MODE_SPIN;
            {gssc_pkg::SW_DOWN, gssc_pkg::SW_MID}:  mode = gssc_pkg::MODE_FIX;
            default:                                mode = gssc_pkg::MODE_OFF;
        endcase
    end

    assign manual = (mode == gssc_pkg::MODE_SHOOT) || (mode == gssc_pkg::MODE_SPIN) ||
                    (mode == gssc_pkg::MODE_FIX);

    // stick nudge, rounded to nearest with ties away from zero
    assign stick_abs  = pitch_stick[10] ? (~pitch_stick[10:0] + 11'd1) : pitch_stick[10:0];
    assign nudge_num  = 17'(stick_abs) * 17'd100 + 17'd33;
    assign nudge_prod = 34'(nudge_num) * 34'(gssc_pkg::NUDGE_RECIP);
    assign nudge_mag  = nudge_prod[33:gssc_pkg::NUDGE_SHIFT];
    assign nudge_d    = pitch_stick[10] ? -$signed({14'd0, nudge_mag})
                                        :  $signed({14'd0, nudge_mag});
    assign accum_ext  = 25'(pitch_accum_reg);
    assign manual_sum = accum_ext + nudge_d;

    // pitch triangle sweep
    assign pstep_ext = $signed({8'd0, cfg.pitch_step});
    always_comb begin
        scan_pdown = pitch_down_reg;
        if (pitch_down_reg) begin
            pitch_move = accum_ext - pstep_ext;
            scan_pitch = pitch_move;
            if (pitch_move < 25'(cfg.pitch_bottom)) begin
                scan_pitch = 25'(cfg.pitch_bottom);
                scan_pdown = 1'b0;
            end
        end else begin
            pitch_move = accum_ext + pstep_ext;
            scan_pitch = pitch_move;
            if (pitch_move > 25'(cfg.pitch_top)) begin
                scan_pitch = 25'(cfg.pitch_top);
                scan_pdown = 1'b1;
            end
        end
    end

    // yaw sweep with reversal bands
    assign band_high = (yaw_motor_angle > cfg.yaw_high_turn) &&
                       (yaw_motor_angle < cfg.yaw_high_edge);
    assign band_low  = (yaw_motor_angle > cfg.yaw_low_edge) &&
                       (yaw_motor_angle < cfg.yaw_low_turn);
    assign scan_ydown = band_high ? 1'b1 : (band_low ? 1'b0 : yaw_down_reg);
    assign yaw_move   = scan_ydown ? (33'(yaw_accum_reg) - $signed({23'd0, cfg.yaw_step}))
                                   : (33'(yaw_accum_reg) + $signed({23'd0, cfg.yaw_step}));
    always_comb begin
        if (yaw_move[32] != yaw_move[31]) begin
            scan_yaw = yaw_move[32] ? {1'b1, 31'd0} : {1'b0, {31{1'b1}}};
        end else begin
            scan_yaw = yaw_move[31:0];
        end
    end

    // lost-target counting
    assign lost_inc  = {1'b0, lost_reg} + (gssc_pkg::LOST_W + 1)'(1);
    assign lost_over = lost_inc > (gssc_pkg::LOST_W + 1)'(LOST_TIMEOUT);

    // next state of one tick
    always_comb begin
        pitch_accum_next = pitch_accum_reg;
        yaw_accum_next   = yaw_accum_reg;
        pitch_down_next  = pitch_down_reg;
        yaw_down_next    = yaw_down_reg;
        lost_next        = lost_reg;
        scanning         = 1'b0;
        if (manual) begin
            pitch_accum_next = clamp_pitch(manual_sum);
        end else if (mode == gssc_pkg::MODE_AUTO) begin
            if (target_found) begin
                lost_next = '0;
            end else if (lost_over) begin
                lost_next        = gssc_pkg::LOST_W'(LOST_TIMEOUT);
                scanning         = 1'b1;
                pitch_accum_next = clamp_pitch(scan_pitch);
                pitch_down_next  = scan_pdown;
                yaw_down_next    = scan_ydown;
                yaw_accum_next   = scan_yaw;
            end else begin
                lost_next = lost_inc[gssc_pkg::LOST_W-1:0];
            end
        end
    end

    // state update on each stepped tick
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pitch_accum_reg <= '0;
            yaw_accum_reg   <= '0;
            pitch_down_reg  <= 1'b0;
            yaw_down_reg    <= 1'b0;
            lost_reg        <= '0;
        end else if (step_en) begin
            pitch_accum_reg <= pitch_accum_next;
            yaw_accum_reg   <= yaw_accum_next;
            pitch_down_reg  <= pitch_down_next;
            yaw_down_reg    <= yaw_down_next;
            lost_reg        <= lost_next;
        end
    end

    // result of the tick shows the updated targets
    assign pitch_cmd      = pitch_accum_next;
    assign yaw_cmd        = yaw_accum_next;
    assign drive_mode     = mode;
    assign vision_enabled = (mode == gssc_pkg::MODE_AUTO);

endmodule

`default_nettype wire

### rtl/gssc_checker.sv
// port-level checks of the gimbal search-scan controller, bound to the top level
`default_nettype none

`include "gimbal_search_scan_controller_macros.svh"

module gssc_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [63:0] m_tdata
);

    // stalled result stays put
    `GSSC_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result changed while stalled")

    // vision flag follows the decoded mode
    `GSSC_ASSERT_SAME(a_vision_mode, aclk, aresetn, m_tvalid, m_tdata[58] == (m_tdata[57:55] == gssc_pkg::MODE_AUTO), "vision flag disagrees with mode")

    // scan steps happen only in auto mode
    `GSSC_ASSERT_SAME(a_scan_auto, aclk, aresetn, m_tvalid && m_tdata[59], m_tdata[58] && (m_tdata[57:55] == gssc_pkg::MODE_AUTO), "scan step outside auto mode")

    // pitch target stays within saturation bounds
    `GSSC_ASSERT_SAME(a_pitch_range, aclk, aresetn, m_tvalid, ($signed(m_tdata[22:0]) <= gssc_pkg::PITCH_LIMIT) && ($signed(m_tdata[22:0]) >= -gssc_pkg::PITCH_LIMIT), "pitch target out of range")

endmodule

bind gimbal_search_scan_controller gssc_checker u_gssc_checker (.*);

`default_nettype wire

### tb/sv/gimbal_scan_checker.sv
// checker for the gimbal search-scan controller: predicts each tick and compares results
module gimbal_scan_checker
    import gssc_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    input  logic              s_tready,
    input  logic [31:0]       s_tdata,
    input  logic              m_tvalid,
    input  logic              m_tready,
    input  logic [63:0]       m_tdata,
    input  logic              cfg_valid,
    input  logic              cfg_ready,
    input  logic [2:0]        cfg_addr,
    input  logic [22:0]       cfg_wdata,
    output int unsigned       n_pending,
    output int unsigned       n_fail
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic signed [22:0] pitch;
        logic signed [31:0] yaw;
        mode_t              mode;
        logic               vision;
        logic               scan;
    } gimbal_out_t;

    // predicted controller state and register copy
    cfg_t               live_cfg;
    logic signed [22:0] pitch_acc;
    logic signed [31:0] yaw_acc;
    logic               pitch_down;
    logic               yaw_down;
    int unsigned        lost_cnt;

    gimbal_out_t expected_ticks[$];
    int unsigned n_results;

    initial begin
        n_pending = 0;
        n_fail    = 0;
        n_results = 0;
    end

    function automatic logic signed [22:0] sat_pitch(longint v);
        if (v > longint'(PITCH_LIMIT)) begin
            return PITCH_LIMIT;
        end
        if (v < -longint'(PITCH_LIMIT)) begin
            return -PITCH_LIMIT;
        end
        return 23'(v);
    endfunction

    // one control tick: mode decode, manual nudge or lost counting and scan step
    function automatic gimbal_out_t advance_gimbal(logic [31:0] d);
        logic [1:0]         sl;
        logic [1:0]         sr;
        logic signed [10:0] stick;
        logic               found;
        int unsigned        angle;
        mode_t              mode;
        longint             p;
        longint             y;
        longint             nudge;
        gimbal_out_t        r;
        sl    = d[1:0];
        sr    = d[3:2];
        stick = $signed(d[14:4]);
        found = d[15];
        angle = d[28:16];

        if (sl == SW_UP && sr == SW_DOWN) begin
            mode = MODE_AUTO;
        end else if (sl == SW_DOWN && sr == SW_DOWN) begin
            mode = MODE_FOLLOW;
        end else if (sl == SW_MID && sr == SW_MID) begin
            mode = MODE_UNFOLLOW;
        end else if (sl == SW_MID && sr == SW_UP) begin
            mode = MODE_SHOOT;
        end else if (sl == SW_MID && sr == SW_DOWN) begin
            mode = MODE_SPIN;
        end else if (sl == SW_DOWN && sr == SW_MID) begin
            mode = MODE_FIX;
        end else begin
            mode = MODE_OFF;
        end
        r.scan = 1'b0;

        if (mode == MODE_SHOOT || mode == MODE_SPIN || mode == MODE_FIX) begin
            // stick scaled to micro-radians, rounded half away from zero
            nudge = longint'(stick) * 1000;
            if (nudge < 0) begin
                nudge = -((-nudge + 330) / 660);
            end else begin
                nudge = (nudge + 330) / 660;
            end
            pitch_acc = sat_pitch(longint'(pitch_acc) + nudge);
        end else if (mode == MODE_AUTO) begin
            if (found) begin
                lost_cnt = 0;
            end else if (lost_cnt + 1 > LOST_TIMEOUT_DEF) begin
                lost_cnt = LOST_TIMEOUT_DEF;
                r.scan   = 1'b1;
                // pitch triangle, limits taken as written even when crossed
                p = longint'(pitch_acc);
                if (pitch_down) begin
                    p = p - longint'(live_cfg.pitch_step);
                    if (p < longint'($signed(live_cfg.pitch_bottom))) begin
                        p          = longint'($signed(live_cfg.pitch_bottom));
                        pitch_down = 1'b0;
                    end
                end else begin
                    p = p + longint'(live_cfg.pitch_step);
                    if (p > longint'($signed(live_cfg.pitch_top))) begin
                        p          = longint'($signed(live_cfg.pitch_top));
                        pitch_down = 1'b1;
                    end
                end
                pitch_acc = sat_pitch(p);
                // yaw reverses only inside the encoder bands
                if (angle > live_cfg.yaw_high_turn && angle < live_cfg.yaw_high_edge) begin
                    yaw_down = 1'b1;
                end else if (angle > live_cfg.yaw_low_edge &&
                             angle < live_cfg.yaw_low_turn) begin
                    yaw_down = 1'b0;
                end
                y = longint'(yaw_acc);
                y = yaw_down ? y - longint'(live_cfg.yaw_step)
                             : y + longint'(live_cfg.yaw_step);
                if (y > 64'sd2147483647) begin
                    y = 64'sd2147483647;
                end else if (y < -64'sd2147483648) begin
                    y = -64'sd2147483648;
                end
                yaw_acc = 32'(y);
            end else begin
                lost_cnt = lost_cnt + 1;
            end
        end

        r.pitch  = pitch_acc;
        r.yaw    = yaw_acc;
        r.mode   = mode;
        r.vision = (mode == MODE_AUTO);
        return r;
    endfunction

    // watch the three channels at each rising edge
    always @(posedge aclk) begin
        gimbal_out_t want;
        gimbal_out_t got;
        if (!aresetn) begin
            live_cfg   = '{17'd1000, 10'd3, 23'sd200000, -23'sd200000,
                           13'd1950, 13'd2050, 13'd6700, 13'd6800};
            pitch_acc  = '0;
            yaw_acc    = '0;
            pitch_down = 1'b0;
            yaw_down   = 1'b0;
            lost_cnt   = 0;
            expected_ticks.delete();
        end else begin
            // register write transaction
            if (cfg_valid && cfg_ready) begin
                case (cfg_idx_t'(cfg_addr))
                    REG_PITCH_STEP:    live_cfg.pitch_step    = cfg_wdata[16:0];
                    REG_YAW_STEP:      live_cfg.yaw_step      = cfg_wdata[9:0];
                    REG_PITCH_TOP:     live_cfg.pitch_top     = cfg_wdata;
                    REG_PITCH_BOTTOM:  live_cfg.pitch_bottom  = cfg_wdata;
                    REG_YAW_LOW_EDGE:  live_cfg.yaw_low_edge  = cfg_wdata[12:0];
                    REG_YAW_LOW_TURN:  live_cfg.yaw_low_turn  = cfg_wdata[12:0];
                    REG_YAW_HIGH_TURN: live_cfg.yaw_high_turn = cfg_wdata[12:0];
                    REG_YAW_HIGH_EDGE: live_cfg.yaw_high_edge = cfg_wdata[12:0];
                    default: ;
                endcase
            end

            // result transaction against the oldest prediction
            if (m_tvalid && m_tready) begin
                got.pitch  = m_tdata[22:0];
                got.yaw    = m_tdata[54:23];
                got.mode   = mode_t'(m_tdata[57:55]);
                got.vision = m_tdata[58];
                got.scan   = m_tdata[59];
                if (expected_ticks.size() == 0) begin
                    if (n_fail < 10) begin
                        $display("result %0d arrived with no tick outstanding", n_results);
                    end
                    n_fail++;
                end else begin
                    want = expected_ticks.pop_front();
                    if (got.pitch !== want.pitch || got.yaw !== want.yaw ||
                        got.mode !== want.mode || got.vision !== want.vision ||
                        got.scan !== want.scan) begin
                        if (n_fail < 10) begin
                            $display("result %0d: expected pitch %0d yaw %0d mode %0d vis %0b scan %0b",
                                     n_results, want.pitch, want.yaw, want.mode,
                                     want.vision, want.scan);
                            $display("result %0d: actual   pitch %0d yaw %0d mode %0d vis %0b scan %0b",
                                     n_results, got.pitch, got.yaw, m_tdata[57:55],
                                     got.vision, got.scan);
                        end
                        n_fail++;
                    end
                end
                n_results++;
            end

            // tick transaction
            if (s_tvalid && s_tready) begin
                expected_ticks.push_back(advance_gimbal(s_tdata));
            end
        end
        n_pending = expected_ticks.size();
    end

endmodule

### tb/sv/tb_top.sv
// top of the gimbal search-scan controller testbench: clock, reset, stimulus and verdict
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import gssc_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 400000;

    logic        aclk;
    logic        aresetn   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata   = '0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [63:0] m_tdata;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_addr  = REG_PITCH_STEP;
    logic [22:0] cfg_wdata = '0;

    int unsigned n_pending;
    int unsigned n_fail;

    bit          stall_request = 1'b0;
    int unsigned snd_quiet     = 0;
    cfg_t        band_cfg;
    cfg_t        plan[6];

    gimbal_search_scan_controller i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    gimbal_scan_checker i_checker (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .n_pending (n_pending),
        .n_fail    (n_fail)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // run limit
    initial begin
        repeat (CYCLE_LIMIT) @(posedge aclk);
        $display("TEST FAILED");
        $finish;
    end

    // idle cycles before a transaction, with occasional stretches of none
    function automatic int unsigned draw_gap(inout int unsigned quiet_run);
        if (quiet_run > 0) begin
            quiet_run--;
            return 0;
        end
        if ($urandom_range(0, 9) == 0) begin
            quiet_run = $urandom_range(10, 40);
            return 0;
        end
        return $urandom_range(0, 19);
    endfunction

    function automatic logic [31:0] pack_tick(logic [1:0] sl, logic [1:0] sr,
                                              logic signed [10:0] stick, logic found,
                                              logic [12:0] angle);
        return {3'b000, angle, found, stick, sr, sl};
    endfunction

    // angle spread over the whole encoder and the two reversal bands
    function automatic logic [12:0] pick_angle();
        case ($urandom_range(0, 2))
            0: return 13'($urandom_range(0, 8191));
            1: return 13'($urandom_range(band_cfg.yaw_high_turn, band_cfg.yaw_high_edge));
            default: return 13'($urandom_range(band_cfg.yaw_low_edge, band_cfg.yaw_low_turn));
        endcase
    endfunction

    function automatic logic signed [10:0] pick_stick();
        if ($urandom_range(0, 1) == 0) begin
            return 11'($urandom_range(0, 2047));
        end
        return 11'(int'($urandom_range(0, 1320)) - 660);
    endfunction

    // auto mode, target lost: the tick that drives the search scan
    function automatic logic [31:0] lost_tick();
        return pack_tick(SW_UP, SW_DOWN, pick_stick(), 1'b0, pick_angle());
    endfunction

    // any switch combination other than auto
    function automatic logic [31:0] manual_tick();
        logic [1:0] sl;
        logic [1:0] sr;
        do begin
            sl = 2'($urandom_range(0, 3));
            sr = 2'($urandom_range(0, 3));
        end while (sl == SW_UP && sr == SW_DOWN);
        return pack_tick(sl, sr, pick_stick(), 1'($urandom_range(0, 1)), pick_angle());
    endfunction

    task automatic send_tick(input logic [31:0] d);
        int unsigned gap;
        gap = draw_gap(snd_quiet);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= d;
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
    endtask

    task automatic write_reg(input cfg_idx_t idx, input logic [22:0] value);
        cfg_valid <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= value;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
    endtask

    // drain all results, then rewrite every register
    task automatic load_settings(input cfg_t c);
        s_tvalid <= 1'b0;
        while (n_pending != 0) @(negedge aclk);
        repeat (4) @(negedge aclk);
        write_reg(REG_PITCH_STEP, 23'(c.pitch_step));
        write_reg(REG_YAW_STEP, 23'(c.yaw_step));
        write_reg(REG_PITCH_TOP, c.pitch_top);
        write_reg(REG_PITCH_BOTTOM, c.pitch_bottom);
        write_reg(REG_YAW_LOW_EDGE, 23'(c.yaw_low_edge));
        write_reg(REG_YAW_LOW_TURN, 23'(c.yaw_low_turn));
        write_reg(REG_YAW_HIGH_TURN, 23'(c.yaw_high_turn));
        write_reg(REG_YAW_HIGH_EDGE, 23'(c.yaw_high_edge));
        cfg_valid <= 1'b0;
        band_cfg = c;
    endtask

    // result side: random ready gaps plus one long hold-off on request
    initial begin
        int unsigned gap;
        int unsigned rcv_quiet;
        rcv_quiet = 0;
        @(posedge aresetn);
        @(negedge aclk);
        forever begin
            gap = draw_gap(rcv_quiet);
            if (stall_request) begin
                stall_request = 1'b0;
                gap = 300;
            end
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            @(negedge aclk);
        end
    end

    // stimulus and verdict
    initial begin
        int unsigned lost_left;
        int unsigned n_sent;
        int          top_pick;
        int          bottom_pick;
        band_cfg = '{17'd1000, 10'd3, 23'sd200000, -23'sd200000,
                     13'd1950, 13'd2050, 13'd6700, 13'd6800};
        plan[0]  = '{17'd100000, 10'd1000, 23'sd3141593, -23'sd3141593,
                     13'd100, 13'd300, 13'd7800, 13'd8000};
        // bands covering all of the encoder but its two end codes, no motion at all
        plan[1]  = '{17'd0, 10'd0, 23'sd0, 23'sd0, 13'd0, 13'd8191, 13'd0, 13'd8191};
        // limits past saturation, empty bands, widest steps
        plan[2]  = '{17'd131071, 10'd1023, 23'h3FFFFF, 23'h400000,
                     13'd8191, 13'd0, 13'd8191, 13'd0};
        // crossed pitch limits
        plan[3]  = '{17'd7000, 10'd17, -23'sd100000, 23'sd100000,
                     13'd1000, 13'd3000, 13'd5000, 13'd7000};
        // drive pitch down into the lower saturation
        plan[4]  = '{17'd131071, 10'd512, 23'sd0, 23'h400000,
                     13'd2000, 13'd2100, 13'd6000, 13'd6100};
        top_pick    = int'($urandom_range(0, 6283186)) - 3141593;
        bottom_pick = int'($urandom_range(0, 6283186)) - 3141593;
        plan[5]  = '{17'($urandom_range(0, 100000)), 10'($urandom_range(0, 1000)),
                     23'(top_pick), 23'(bottom_pick),
                     13'($urandom_range(0, 8191)), 13'($urandom_range(0, 8191)),
                     13'($urandom_range(0, 8191)), 13'($urandom_range(0, 8191))};

        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // every mode, switch value zero, stick extremes, target seen and lost
        send_tick(pack_tick(2'd0, 2'd0, 11'sd0, 1'b0, 13'd0));
        send_tick(pack_tick(SW_UP, SW_UP, 11'sd5, 1'b1, 13'd4096));
        send_tick(pack_tick(SW_MID, 2'd0, -11'sd5, 1'b0, 13'd100));
        send_tick(pack_tick(SW_DOWN, SW_DOWN, 11'sd660, 1'b0, 13'd6750));
        send_tick(pack_tick(SW_MID, SW_MID, -11'sd660, 1'b1, 13'd2000));
        send_tick(pack_tick(SW_MID, SW_UP, 11'sd660, 1'b0, 13'd0));
        send_tick(pack_tick(SW_MID, SW_UP, -11'sd660, 1'b0, 13'd0));
        send_tick(pack_tick(SW_MID, SW_DOWN, 11'sd1023, 1'b0, 13'd0));
        send_tick(pack_tick(SW_MID, SW_DOWN, -11'sd1024, 1'b1, 13'd8191));
        send_tick(pack_tick(SW_DOWN, SW_MID, 11'sd1, 1'b0, 13'd0));
        send_tick(pack_tick(SW_DOWN, SW_MID, -11'sd1, 1'b0, 13'd0));
        send_tick(pack_tick(SW_DOWN, SW_MID, 11'sd33, 1'b0, 13'd0));
        send_tick(pack_tick(SW_MID, SW_UP, 11'sd0, 1'b0, 13'd0));
        send_tick(pack_tick(SW_MID, SW_UP, 11'sd331, 1'b0, 13'd0));
        send_tick(pack_tick(SW_MID, SW_UP, -11'sd329, 1'b0, 13'd0));
        send_tick(pack_tick(SW_UP, SW_DOWN, 11'sd0, 1'b1, 13'd8191));
        send_tick(pack_tick(SW_UP, SW_DOWN, 11'sd0, 1'b0, 13'd0));
        send_tick(pack_tick(SW_UP, SW_DOWN, 11'sd0, 1'b0, 13'd6750));
        send_tick(pack_tick(SW_MID, 2'd0, -11'sd1, 1'b1, 13'd8191));
        send_tick(pack_tick(2'd0, SW_MID, 11'sd0, 1'b1, 13'd0));
        send_tick(pack_tick(SW_UP, SW_DOWN, -11'sd1, 1'b1, 13'd8191));

        // count up to the lost timeout and scan with reset settings,
        // manual ticks mixed in; the result side holds off once
        lost_left = 830;
        n_sent    = 0;
        while (lost_left > 0) begin
            if (n_sent == 300) begin
                stall_request = 1'b1;
            end
            if ($urandom_range(0, 19) == 0) begin
                send_tick(manual_tick());
            end else begin
                send_tick(lost_tick());
                lost_left--;
            end
            n_sent++;
        end

        // scan under each setting; lost count carries over between phases
        foreach (plan[k]) begin
            load_settings(plan[k]);
            repeat (70) begin
                if ($urandom_range(0, 9) == 0) begin
                    send_tick(manual_tick());
                end else begin
                    send_tick(lost_tick());
                end
            end
        end

        // unrestricted ticks, targets coming and going
        repeat (60) begin
            send_tick(32'($urandom()) & 32'h1FFF_FFFF);
        end
        s_tvalid <= 1'b0;

        while (n_pending != 0) @(negedge aclk);
        repeat (10) @(negedge aclk);
        if (n_fail == 0 && n_pending == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
